// File: src/css_pkg.sv
// Shared types, constants and register map for the charge stage sequencer.
`timescale 1ns / 1ps
`default_nettype none

package css_pkg;

    localparam int unsigned MV_W       = 16;
    localparam int unsigned TIMER_W    = 23;
    localparam int unsigned CFG_DATA_W = 32;
    localparam int unsigned CFG_ADDR_W = 5;
    localparam int unsigned REG_IDX_W  = 3;

    localparam int unsigned CV_HOLD_MS_DEF     = 600000;
    localparam int unsigned FLOAT_RETRY_MS_DEF = 3600000;

    localparam logic [TIMER_W-1:0] TIMER_MAX = {TIMER_W{1'b1}};

    // Register indexes (byte address = 4 * index)
    localparam logic [REG_IDX_W-1:0] REG_OVERVOLT  = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_UNDERVOLT = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_CC_START  = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_CV_SWITCH = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_RECHARGE  = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_TAPER     = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_SLOW_TICK = 3'd6;

    // Register reset values
    localparam logic [MV_W-1:0] RST_OVERVOLT  = 16'd15000;
    localparam logic [MV_W-1:0] RST_UNDERVOLT = 16'd5000;
    localparam logic [MV_W-1:0] RST_CC_START  = 16'd13600;
    localparam logic [MV_W-1:0] RST_CV_SWITCH = 16'd14000;
    localparam logic [MV_W-1:0] RST_RECHARGE  = 16'd11200;
    localparam logic [MV_W-1:0] RST_TAPER     = 16'd900;
    localparam logic [MV_W-1:0] RST_SLOW_TICK = 16'd1000;

    typedef enum logic [1:0] {
        ST_IDLE  = 2'd0,
        ST_CC    = 2'd1,
        ST_CV    = 2'd2,
        ST_FLOAT = 2'd3
    } stage_t;

    typedef enum logic [1:0] {
        FN_ENABLE    = 2'd0,
        FN_DISABLE   = 2'd1,
        FN_CTRL_TICK = 2'd2,
        FN_SLOW_TICK = 2'd3
    } func_t;

    typedef struct packed {
        logic [MV_W-1:0] overvolt_limit_mv;
        logic [MV_W-1:0] undervolt_limit_mv;
        logic [MV_W-1:0] cc_start_below_mv;
        logic [MV_W-1:0] cv_switch_at_mv;
        logic [MV_W-1:0] recharge_below_mv;
        logic [MV_W-1:0] taper_current_ma;
        logic [MV_W-1:0] slow_tick_ms;
    } cfg_t;

    typedef struct packed {
        stage_t             stage;
        logic [TIMER_W-1:0] hold_ms;
        logic [TIMER_W-1:0] retry_ms;
    } seq_state_t;

    typedef struct packed {
        stage_t stage;
        logic   pwm_run;
        logic   reset_current_loop;
        logic   reset_voltage_loop;
        logic   protect_trip;
    } result_t;

    // Saturating timer add
    function automatic logic [TIMER_W-1:0] timer_add(input logic [TIMER_W-1:0] t,
                                                      input logic [MV_W-1:0]    inc);
        logic [TIMER_W:0] sum;
        sum = {1'b0, t} + {{(TIMER_W+1-MV_W){1'b0}}, inc};
        return sum[TIMER_W] ? TIMER_MAX : sum[TIMER_W-1:0];
    endfunction

endpackage

`default_nettype wire

// File: src/charge_stage_sequencer_top.sv
// Top level of the charge stage sequencer: register bank and sequencer core.
`timescale 1ns / 1ps
`default_nettype none

// Three-stage charger sequencer (idle, constant current, constant voltage, float).
// Each request on the input channel is one event (func: enable, disable, control
// tick, slow tick) carrying battery millivolts and charge milliamps, and produces
// exactly one result: the stage after the event, pwm_run, the two loop-clear
// pulses and the protection-trip flag. A request is registered, evaluated by one
// short compare-and-update step against the stage and the two 23-bit saturating
// timers, and its result registered, so the block takes one request per clock
// while out_ready does not stall the result register. out_valid rises when the
// request moves from the input register into the result register; the single
// state update per request in the core sets that rate.
// The input register and result register decouple the sides: a new request is
// accepted while a finished result is still waiting for out_ready. Thresholds
// and the slow-tick step live in seven 16-bit APB registers at byte addresses
// 0x00..0x18; write them only while no request is in flight. CV_HOLD_MS and
// FLOAT_RETRY_MS are the CV hold and float retry times in milliseconds.

module charge_stage_sequencer_top
    import css_pkg::*;
#(
    parameter int unsigned CV_HOLD_MS     = CV_HOLD_MS_DEF,
    parameter int unsigned FLOAT_RETRY_MS = FLOAT_RETRY_MS_DEF
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    // configuration
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [CFG_ADDR_W-1:0] paddr,
    input  wire logic [CFG_DATA_W-1:0] pwdata,
    output logic      [CFG_DATA_W-1:0] prdata,
    output logic                       pready,
    // request channel
    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire logic [1:0]            func,
    input  wire logic [MV_W-1:0]       battery_mv,
    input  wire logic [MV_W-1:0]       charge_ma,
    // result channel
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output logic [1:0]                 stage,
    output logic                       pwm_run,
    output logic                       reset_current_loop,
    output logic                       reset_voltage_loop,
    output logic                       protect_trip
);

    cfg_t    cfg;
    result_t result;

    css_cfg_regs u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    css_core #(
        .CV_HOLD_MS     (CV_HOLD_MS),
        .FLOAT_RETRY_MS (FLOAT_RETRY_MS)
    ) u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .func       (func),
        .battery_mv (battery_mv),
        .charge_ma  (charge_ma),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .result     (result)
    );

    assign stage              = result.stage;
    assign pwm_run            = result.pwm_run;
    assign reset_current_loop = result.reset_current_loop;
    assign reset_voltage_loop = result.reset_voltage_loop;
    assign protect_trip       = result.protect_trip;

endmodule

`default_nettype wire

// File: src/css_cfg_regs.sv
// APB configuration register bank for the charge stage sequencer.
`timescale 1ns / 1ps
`default_nettype none

module css_cfg_regs
    import css_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [CFG_ADDR_W-1:0] paddr,
    input  wire logic [CFG_DATA_W-1:0] pwdata,
    output logic      [CFG_DATA_W-1:0] prdata,
    output logic                       pready,
    output cfg_t                       cfg
);

    cfg_t                 cfg_reg;
    logic                 wr_en;
    logic [REG_IDX_W-1:0] idx;
    logic [MV_W-1:0]      wdata;
    logic [MV_W-1:0]      rd_val;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite;
    assign idx    = paddr[CFG_ADDR_W-1:2];
    assign wdata  = pwdata[MV_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.overvolt_limit_mv  <= RST_OVERVOLT;
            cfg_reg.undervolt_limit_mv <= RST_UNDERVOLT;
            cfg_reg.cc_start_below_mv  <= RST_CC_START;
            cfg_reg.cv_switch_at_mv    <= RST_CV_SWITCH;
            cfg_reg.recharge_below_mv  <= RST_RECHARGE;
            cfg_reg.taper_current_ma   <= RST_TAPER;
            cfg_reg.slow_tick_ms       <= RST_SLOW_TICK;
        end
        else if (wr_en)
        begin
            case (idx)
                REG_OVERVOLT:  cfg_reg.overvolt_limit_mv  <= wdata;
                REG_UNDERVOLT: cfg_reg.undervolt_limit_mv <= wdata;
                REG_CC_START:  cfg_reg.cc_start_below_mv  <= wdata;
                REG_CV_SWITCH: cfg_reg.cv_switch_at_mv    <= wdata;
                REG_RECHARGE:  cfg_reg.recharge_below_mv  <= wdata;
                REG_TAPER:     cfg_reg.taper_current_ma   <= wdata;
                REG_SLOW_TICK: cfg_reg.slow_tick_ms       <= wdata;
                default:       ;  // unmapped: dropped
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            REG_OVERVOLT:  rd_val = cfg_reg.overvolt_limit_mv;
            REG_UNDERVOLT: rd_val = cfg_reg.undervolt_limit_mv;
            REG_CC_START:  rd_val = cfg_reg.cc_start_below_mv;
            REG_CV_SWITCH: rd_val = cfg_reg.cv_switch_at_mv;
            REG_RECHARGE:  rd_val = cfg_reg.recharge_below_mv;
            REG_TAPER:     rd_val = cfg_reg.taper_current_ma;
            REG_SLOW_TICK: rd_val = cfg_reg.slow_tick_ms;
            default:       rd_val = '0;
        endcase
    end

    assign prdata = {{(CFG_DATA_W-MV_W){1'b0}}, rd_val};
    assign cfg    = cfg_reg;

endmodule

`default_nettype wire

// File: src/css_step.sv
// Next-stage and pulse logic for one sequencer request.
`timescale 1ns / 1ps
`default_nettype none

module css_step
    import css_pkg::*;
#(
    parameter int unsigned CV_HOLD_MS     = CV_HOLD_MS_DEF,
    parameter int unsigned FLOAT_RETRY_MS = FLOAT_RETRY_MS_DEF
)
(
    input  wire cfg_t         cfg,
    input  wire seq_state_t   cur,
    input  wire logic [1:0]   func,
    input  wire logic [MV_W-1:0] battery_mv,
    input  wire logic [MV_W-1:0] charge_ma,
    output seq_state_t        nxt,
    output result_t           res
);

    localparam logic [TIMER_W-1:0] HOLD_LIM  = TIMER_W'(CV_HOLD_MS);
    localparam logic [TIMER_W-1:0] RETRY_LIM = TIMER_W'(FLOAT_RETRY_MS);

    logic               running;
    logic [TIMER_W-1:0] hold_inc;
    logic [TIMER_W-1:0] retry_inc;
    logic               rst_i;
    logic               rst_v;
    logic               trip;

    assign running   = (cur.stage != ST_IDLE);
    assign hold_inc  = timer_add(cur.hold_ms, cfg.slow_tick_ms);
    assign retry_inc = timer_add(cur.retry_ms, cfg.slow_tick_ms);

    always_comb
    begin
        nxt   = cur;
        rst_i = 1'b0;
        rst_v = 1'b0;
        trip  = 1'b0;
        case (func_t'(func))
            FN_ENABLE:
            begin
                if (!running)
                begin
                    nxt.stage   = (battery_mv < cfg.cc_start_below_mv) ? ST_CC : ST_FLOAT;
                    nxt.hold_ms = '0;
                    rst_i       = 1'b1;
                    rst_v       = 1'b1;
                end
            end
            FN_DISABLE:
            begin
                nxt.stage = ST_IDLE;
            end
            FN_CTRL_TICK:
            begin
                if (running && (battery_mv > cfg.overvolt_limit_mv ||
                                battery_mv < cfg.undervolt_limit_mv))
                begin
                    nxt.stage = ST_IDLE;
                    trip      = 1'b1;
                end
            end
            FN_SLOW_TICK:
            begin
                case (cur.stage)
                    ST_CC:
                    begin
                        if (battery_mv >= cfg.cv_switch_at_mv)
                        begin
                            nxt.stage   = ST_CV;
                            nxt.hold_ms = '0;
                            rst_v       = 1'b1;
                        end
                    end
                    ST_CV:
                    begin
                        if (charge_ma < cfg.taper_current_ma)
                        begin
                            nxt.hold_ms = hold_inc;
                            if (hold_inc >= HOLD_LIM)
                            begin
                                nxt.stage = ST_FLOAT;
                                rst_v     = 1'b1;
                            end
                        end
                        else
                        begin
                            nxt.hold_ms = '0;
                        end
                    end
                    ST_FLOAT:
                    begin
                        if (battery_mv < cfg.recharge_below_mv)
                        begin
                            nxt.retry_ms = retry_inc;
                            if (retry_inc >= RETRY_LIM)
                            begin
                                nxt.stage    = ST_CC;
                                nxt.retry_ms = '0;
                                rst_i        = 1'b1;
                            end
                        end
                        else
                        begin
                            nxt.retry_ms = '0;
                        end
                    end
                    default: ;  // idle: tick ignored
                endcase
            end
            default: ;
        endcase

        res.stage              = nxt.stage;
        res.pwm_run            = (nxt.stage != ST_IDLE);
        res.reset_current_loop = rst_i;
        res.reset_voltage_loop = rst_v;
        res.protect_trip       = trip;
    end

endmodule

`default_nettype wire

// File: src/css_core.sv
// Input register, sequencer state and result register.
`timescale 1ns / 1ps
`default_nettype none

module css_core
    import css_pkg::*;
#(
    parameter int unsigned CV_HOLD_MS     = CV_HOLD_MS_DEF,
    parameter int unsigned FLOAT_RETRY_MS = FLOAT_RETRY_MS_DEF
)
(
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire cfg_t            cfg,
    input  wire logic            in_valid,
    output logic                 in_ready,
    input  wire logic [1:0]      func,
    input  wire logic [MV_W-1:0] battery_mv,
    input  wire logic [MV_W-1:0] charge_ma,
    output logic                 out_valid,
    input  wire logic            out_ready,
    output result_t              result
);

    logic            in_valid_reg;
    logic [1:0]      func_reg;
    logic [MV_W-1:0] mv_reg;
    logic [MV_W-1:0] ma_reg;
    seq_state_t      state_reg;
    seq_state_t      state_next;
    logic            out_valid_reg;
    result_t         result_reg;
    result_t         result_next;
    logic            advance;

    // request moves from input stage to result stage
    assign advance  = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || advance;

    css_step #(
        .CV_HOLD_MS     (CV_HOLD_MS),
        .FLOAT_RETRY_MS (FLOAT_RETRY_MS)
    ) u_step (
        .cfg        (cfg),
        .cur        (state_reg),
        .func       (func_reg),
        .battery_mv (mv_reg),
        .charge_ma  (ma_reg),
        .nxt        (state_next),
        .res        (result_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= '{stage: ST_IDLE, hold_ms: '0, retry_ms: '0};
        end
        else
        begin
            if (in_ready)
            begin
                in_valid_reg <= in_valid;
            end
            if (advance)
            begin
                state_reg     <= state_next;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            func_reg <= func;
            mv_reg   <= battery_mv;
            ma_reg   <= charge_ma;
        end
        if (advance)
        begin
            result_reg <= result_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign result    = result_reg;

    // A trip always lands in idle
    a_trip_idle: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && result_reg.protect_trip |-> result_reg.stage == ST_IDLE)
        else $error("protect trip with stage not idle");

    // Enable from idle clears the hold timer
    a_enable_clears_hold: assert property (@(posedge clk) disable iff (!rst_n)
        advance && func_reg == FN_ENABLE && state_reg.stage == ST_IDLE
        |=> state_reg.hold_ms == '0)
        else $error("hold timer not cleared on enable");

    // Pending request is never dropped while stalled
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !advance |=> in_valid_reg && $stable(func_reg) && $stable(mv_reg))
        else $error("stalled request lost");

    // State only moves when a request advances
    a_state_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> $stable(state_reg))
        else $error("state changed without a request");

endmodule

`default_nettype wire

// File: bench/charge_stage_checker.sv
// Charge stage sequencer checker: tracks config writes, predicts each result, compares outputs.
`timescale 1ns / 1ps

module charge_stage_checker
    import css_pkg::*;
#(
    parameter int unsigned CV_HOLD_MS     = CV_HOLD_MS_DEF,
    parameter int unsigned FLOAT_RETRY_MS = FLOAT_RETRY_MS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    input  logic                  pready,
    input  logic                  in_valid,
    input  logic                  in_ready,
    input  logic [1:0]            func,
    input  logic [MV_W-1:0]       battery_mv,
    input  logic [MV_W-1:0]       charge_ma,
    input  logic                  out_valid,
    input  logic                  out_ready,
    input  logic [1:0]            stage,
    input  logic                  pwm_run,
    input  logic                  reset_current_loop,
    input  logic                  reset_voltage_loop,
    input  logic                  protect_trip,
    output int                    fail_count,
    output int                    pending_results
);

    cfg_t               limits;
    stage_t             charger_stage;
    logic [TIMER_W-1:0] hold_ms;
    logic [TIMER_W-1:0] retry_ms;
    result_t            expected_results[$];
    result_t            want;
    result_t            predicted;

    function automatic logic [TIMER_W-1:0] advance_timer(input logic [TIMER_W-1:0] t,
                                                         input logic [MV_W-1:0]    step);
        logic [TIMER_W:0] total;
        total = {1'b0, t} + (TIMER_W+1)'(step);
        if (total > TIMER_MAX)
            return TIMER_MAX;
        return total[TIMER_W-1:0];
    endfunction

    task automatic step_sequencer(input func_t f, input logic [MV_W-1:0] mv,
                                  input logic [MV_W-1:0] ma, output result_t r);
        logic running;
        running = (charger_stage != ST_IDLE);
        r = '0;
        case (f)
            FN_ENABLE:
                if (!running)
                begin
                    charger_stage = (mv < limits.cc_start_below_mv) ? ST_CC : ST_FLOAT;
                    r.reset_current_loop = 1'b1;
                    r.reset_voltage_loop = 1'b1;
                    hold_ms = '0;
                end
            FN_DISABLE:
                charger_stage = ST_IDLE;
            FN_CTRL_TICK:
                if (running && (mv > limits.overvolt_limit_mv || mv < limits.undervolt_limit_mv))
                begin
                    charger_stage = ST_IDLE;
                    r.protect_trip = 1'b1;
                end
            default:
                case (charger_stage)
                    ST_CC:
                        if (mv >= limits.cv_switch_at_mv)
                        begin
                            charger_stage = ST_CV;
                            r.reset_voltage_loop = 1'b1;
                            hold_ms = '0;
                        end
                    ST_CV:
                        if (ma < limits.taper_current_ma)
                        begin
                            hold_ms = advance_timer(hold_ms, limits.slow_tick_ms);
                            if (hold_ms >= CV_HOLD_MS)
                            begin
                                charger_stage = ST_FLOAT;
                                r.reset_voltage_loop = 1'b1;
                            end
                        end
                        else
                        begin
                            hold_ms = '0;
                        end
                    ST_FLOAT:
                        if (mv < limits.recharge_below_mv)
                        begin
                            retry_ms = advance_timer(retry_ms, limits.slow_tick_ms);
                            if (retry_ms >= FLOAT_RETRY_MS)
                            begin
                                charger_stage = ST_CC;
                                r.reset_current_loop = 1'b1;
                                retry_ms = '0;
                            end
                        end
                        else
                        begin
                            retry_ms = '0;
                        end
                    default:
                        ;
                endcase
        endcase
        r.stage   = charger_stage;
        r.pwm_run = (charger_stage != ST_IDLE);
    endtask

    task automatic check_field(input string name, input logic [1:0] exp_val,
                               input logic [1:0] act_val);
        if (act_val !== exp_val)
        begin
            $error("%s: expected %0d, got %0d", name, exp_val, act_val);
            fail_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limits.overvolt_limit_mv  = RST_OVERVOLT;
            limits.undervolt_limit_mv = RST_UNDERVOLT;
            limits.cc_start_below_mv  = RST_CC_START;
            limits.cv_switch_at_mv    = RST_CV_SWITCH;
            limits.recharge_below_mv  = RST_RECHARGE;
            limits.taper_current_ma   = RST_TAPER;
            limits.slow_tick_ms       = RST_SLOW_TICK;
            charger_stage   = ST_IDLE;
            hold_ms         = '0;
            retry_ms        = '0;
            fail_count      = 0;
            pending_results = 0;
            expected_results.delete();
        end
        else
        begin
            // a result leaving here is from an earlier request: retire before queuing
            if (out_valid && out_ready)
            begin
                if (expected_results.size() == 0)
                begin
                    $error("result with no request outstanding");
                    fail_count++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    check_field("stage", want.stage, stage);
                    check_field("pwm_run", want.pwm_run, pwm_run);
                    check_field("reset_current_loop", want.reset_current_loop,
                                reset_current_loop);
                    check_field("reset_voltage_loop", want.reset_voltage_loop,
                                reset_voltage_loop);
                    check_field("protect_trip", want.protect_trip, protect_trip);
                end
            end
            if (psel && penable && pwrite && pready)
            begin
                case (paddr[CFG_ADDR_W-1:2])
                    REG_OVERVOLT:  limits.overvolt_limit_mv  = pwdata[MV_W-1:0];
                    REG_UNDERVOLT: limits.undervolt_limit_mv = pwdata[MV_W-1:0];
                    REG_CC_START:  limits.cc_start_below_mv  = pwdata[MV_W-1:0];
                    REG_CV_SWITCH: limits.cv_switch_at_mv    = pwdata[MV_W-1:0];
                    REG_RECHARGE:  limits.recharge_below_mv  = pwdata[MV_W-1:0];
                    REG_TAPER:     limits.taper_current_ma   = pwdata[MV_W-1:0];
                    REG_SLOW_TICK: limits.slow_tick_ms       = pwdata[MV_W-1:0];
                    default:       ;
                endcase
            end
            if (in_valid && in_ready)
            begin
                step_sequencer(func_t'(func), battery_mv, charge_ma, predicted);
                expected_results.push_back(predicted);
            end
            pending_results = expected_results.size();
        end
    end

endmodule

// File: bench/tb_top.sv
// Testbench top: clock, reset, request and config stimulus, and the final verdict.
`timescale 1ns / 1ps

module tb_top
    import css_pkg::*;
();

    localparam int unsigned HOLD_MS      = CV_HOLD_MS_DEF;
    localparam int unsigned RETRY_MS     = FLOAT_RETRY_MS_DEF;
    localparam int unsigned CYCLE_LIMIT  = 200000;
    localparam int unsigned TAIL_CYCLES  = 8;
    localparam int unsigned PHASES       = 7;
    localparam int unsigned RANDOM_ITEMS = 1950;
    localparam int unsigned IDLE_PCT     = 8;

    // index 7 decodes to nothing; writes there must be dropped
    localparam logic [REG_IDX_W-1:0] REG_SPARE = 3'd7;

    logic                  clk        = 1'b0;
    logic                  rst_n      = 1'b0;
    logic                  psel       = 1'b0;
    logic                  penable    = 1'b0;
    logic                  pwrite     = 1'b0;
    logic [CFG_ADDR_W-1:0] paddr      = '0;
    logic [CFG_DATA_W-1:0] pwdata     = '0;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;
    logic                  in_valid   = 1'b0;
    logic                  in_ready;
    logic [1:0]            func       = FN_DISABLE;
    logic [MV_W-1:0]       battery_mv = '0;
    logic [MV_W-1:0]       charge_ma  = '0;
    logic                  out_valid;
    logic                  out_ready  = 1'b0;
    logic [1:0]            stage;
    logic                  pwm_run;
    logic                  reset_current_loop;
    logic                  reset_voltage_loop;
    logic                  protect_trip;

    int                    fail_count;
    int                    pending_results;

    // when set, neither side inserts idle cycles
    bit                    steady_flow = 1'b0;

    // thresholds currently programmed, used to aim stimulus at the interesting edges
    cfg_t                  cur;

    always #2 clk = ~clk;

    charge_stage_sequencer_top #(
        .CV_HOLD_MS     (HOLD_MS),
        .FLOAT_RETRY_MS (RETRY_MS)
    ) i_dut (
        .clk                (clk),
        .rst_n              (rst_n),
        .psel               (psel),
        .penable            (penable),
        .pwrite             (pwrite),
        .paddr              (paddr),
        .pwdata             (pwdata),
        .prdata             (prdata),
        .pready             (pready),
        .in_valid           (in_valid),
        .in_ready           (in_ready),
        .func               (func),
        .battery_mv         (battery_mv),
        .charge_ma          (charge_ma),
        .out_valid          (out_valid),
        .out_ready          (out_ready),
        .stage              (stage),
        .pwm_run            (pwm_run),
        .reset_current_loop (reset_current_loop),
        .reset_voltage_loop (reset_voltage_loop),
        .protect_trip       (protect_trip)
    );

    charge_stage_checker #(
        .CV_HOLD_MS     (HOLD_MS),
        .FLOAT_RETRY_MS (RETRY_MS)
    ) i_checker (
        .clk                (clk),
        .rst_n              (rst_n),
        .psel               (psel),
        .penable            (penable),
        .pwrite             (pwrite),
        .paddr              (paddr),
        .pwdata             (pwdata),
        .pready             (pready),
        .in_valid           (in_valid),
        .in_ready           (in_ready),
        .func               (func),
        .battery_mv         (battery_mv),
        .charge_ma          (charge_ma),
        .out_valid          (out_valid),
        .out_ready          (out_ready),
        .stage              (stage),
        .pwm_run            (pwm_run),
        .reset_current_loop (reset_current_loop),
        .reset_voltage_loop (reset_voltage_loop),
        .protect_trip       (protect_trip),
        .fail_count         (fail_count),
        .pending_results    (pending_results)
    );

    // Result side back-pressure: random stalls unless a steady stretch is running.
    always @(posedge clk)
    begin
        if (rst_n)
            out_ready <= steady_flow || ($urandom_range(0, 99) >= IDLE_PCT);
    end

    // Random value strictly below a threshold; zero when nothing lies below it.
    function automatic logic [MV_W-1:0] below(input logic [MV_W-1:0] thr);
        if (thr == 0)
            return '0;
        return MV_W'($urandom_range(0, thr - 1));
    endfunction

    function automatic logic [MV_W-1:0] at_or_above(input logic [MV_W-1:0] thr);
        return MV_W'($urandom_range(thr, 16'hFFFF));
    endfunction

    function automatic logic [MV_W-1:0] any_value();
        return MV_W'($urandom_range(0, 16'hFFFF));
    endfunction

    // Called at a rising edge. Holds the request until it is taken; valid is
    // left high so a back-to-back request never toggles it within one step.
    task automatic send_request(input func_t f, input logic [MV_W-1:0] mv,
                                input logic [MV_W-1:0] ma);
        while (!steady_flow && $urandom_range(0, 99) < IDLE_PCT)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid   <= 1'b1;
        func       <= f;
        battery_mv <= mv;
        charge_ma  <= ma;
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    // Stop sending and let every outstanding result come back, plus a short tail.
    // The first negedge lets the checker count a request taken at this edge.
    task automatic wait_for_results();
        in_valid <= 1'b0;
        do
            @(negedge clk);
        while (pending_results != 0);
        repeat (TAIL_CYCLES) @(posedge clk);
    endtask

    // One APB write: setup then access. psel stays up so back-to-back writes
    // do not drop and raise it in the same step; program_config lowers it.
    task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [MV_W-1:0] value);
        logic [MV_W-1:0] junk;
        junk = MV_W'($urandom_range(0, 16'hFFFF));
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {junk, value};
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
    endtask

    // Program the whole register set; upper data bits carry junk to exercise masking.
    task automatic program_config(input cfg_t c);
        write_reg(REG_OVERVOLT,  c.overvolt_limit_mv);
        write_reg(REG_UNDERVOLT, c.undervolt_limit_mv);
        write_reg(REG_CC_START,  c.cc_start_below_mv);
        write_reg(REG_CV_SWITCH, c.cv_switch_at_mv);
        write_reg(REG_RECHARGE,  c.recharge_below_mv);
        write_reg(REG_TAPER,     c.taper_current_ma);
        write_reg(REG_SLOW_TICK, c.slow_tick_ms);
        write_reg(REG_SPARE,     any_value());
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        cur = c;
    endtask

    // Random traffic. Mostly full charge cycles: an enable, then runs of slow
    // ticks that each push toward one transition (voltage up to the CV point,
    // current tapered, voltage sagging in float), sprinkled with control ticks.
    // The rest is raw noise across every field.
    task automatic random_traffic(input int unsigned count);
        int unsigned sent;
        int unsigned runs;
        int unsigned run_len;
        int unsigned flavor;
        int unsigned pick;
        logic [MV_W-1:0] mv;
        logic [MV_W-1:0] ma;
        sent = 0;
        while (sent < count)
        begin
            if ($urandom_range(0, 99) < 15)
            begin
                send_request(func_t'($urandom_range(0, 3)), any_value(), any_value());
                sent++;
            end
            else
            begin
                mv = ($urandom_range(0, 9) < 7) ? below(cur.cc_start_below_mv)
                                                : at_or_above(cur.cc_start_below_mv);
                send_request(FN_ENABLE, mv, any_value());
                sent++;
                runs = $urandom_range(1, 6);
                repeat (runs)
                begin
                    flavor  = $urandom_range(0, 2);
                    run_len = $urandom_range(1, 70);
                    // keep the phase close to its request budget
                    if (run_len > count - sent)
                        run_len = count - sent;
                    repeat (run_len)
                    begin
                        pick = $urandom_range(0, 99);
                        if (pick < 8)
                        begin
                            // in-limit control tick keeps charging going
                            send_request(FN_CTRL_TICK,
                                         MV_W'($urandom_range(cur.undervolt_limit_mv,
                                                              cur.overvolt_limit_mv)),
                                         any_value());
                        end
                        else if (pick < 10)
                        begin
                            send_request(FN_CTRL_TICK, any_value(), any_value());
                        end
                        else
                        begin
                            case (flavor)
                                0:
                                begin
                                    mv = ($urandom_range(0, 3) == 0) ? cur.cv_switch_at_mv
                                                        : at_or_above(cur.cv_switch_at_mv);
                                    ma = any_value();
                                end
                                1:
                                begin
                                    mv = any_value();
                                    ma = below(cur.taper_current_ma);
                                end
                                default:
                                begin
                                    mv = below(cur.recharge_below_mv);
                                    ma = any_value();
                                end
                            endcase
                            send_request(FN_SLOW_TICK, mv, ma);
                        end
                        sent++;
                    end
                end
                if ($urandom_range(0, 9) < 7)
                begin
                    send_request(FN_DISABLE, any_value(), any_value());
                    sent++;
                end
                // occasional full drain mid-phase
                if ($urandom_range(0, 19) == 0)
                    wait_for_results();
            end
        end
    endtask

    // Watchdog: a hang or a lost result ends here.
    initial
    begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("Verification failed");
        $finish;
    end

    initial
    begin : stimulus
        cfg_t        phase_cfg;
        int unsigned phase;

        cur.overvolt_limit_mv  = RST_OVERVOLT;
        cur.undervolt_limit_mv = RST_UNDERVOLT;
        cur.cc_start_below_mv  = RST_CC_START;
        cur.cv_switch_at_mv    = RST_CV_SWITCH;
        cur.recharge_below_mv  = RST_RECHARGE;
        cur.taper_current_ma   = RST_TAPER;
        cur.slow_tick_ms       = RST_SLOW_TICK;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed pass on the reset thresholds (15000/5000/13600/14000/11200/900).
        send_request(FN_SLOW_TICK, 16'd0, 16'd0);          // ticks while idle do nothing
        send_request(FN_CTRL_TICK, 16'hFFFF, 16'hFFFF);    // no trip while idle
        send_request(FN_DISABLE, 16'd0, 16'd0);
        send_request(FN_ENABLE, 16'd0, 16'hFFFF);          // low battery: CC, both clears
        send_request(FN_ENABLE, 16'hFFFF, 16'd0);          // already running: ignored
        send_request(FN_CTRL_TICK, 16'd15000, 16'd0);      // at the overvolt limit: no trip
        send_request(FN_CTRL_TICK, 16'd5000, 16'd0);       // at the undervolt limit: no trip
        send_request(FN_SLOW_TICK, 16'd13999, 16'd0);      // just under CV point: stay CC
        send_request(FN_SLOW_TICK, 16'd14000, 16'd0);      // CV point reached
        send_request(FN_SLOW_TICK, 16'd0, 16'd900);        // current at taper: hold cleared
        send_request(FN_SLOW_TICK, 16'd0, 16'd899);        // below taper: hold advances
        send_request(FN_CTRL_TICK, 16'd15001, 16'd0);      // overvoltage trip
        send_request(FN_ENABLE, 16'd13600, 16'd0);         // not below CC start: float
        send_request(FN_SLOW_TICK, 16'd11199, 16'hFFFF);   // sagging: retry advances
        send_request(FN_SLOW_TICK, 16'd11200, 16'hFFFF);   // recovered: retry cleared
        send_request(FN_CTRL_TICK, 16'd4999, 16'd0);       // undervoltage trip
        send_request(FN_ENABLE, 16'hFFFF, 16'hFFFF);       // full scale: float
        send_request(FN_DISABLE, 16'hFFFF, 16'hFFFF);      // drop to idle, no pulses
        send_request(FN_SLOW_TICK, 16'hFFFF, 16'd0);
        wait_for_results();

        for (phase = 0; phase < PHASES; phase++)
        begin
            phase_cfg = cur;
            case (phase)
                0:
                begin
                    // largest step: hold and retry times are reachable in a few dozen ticks
                    phase_cfg.overvolt_limit_mv  = RST_OVERVOLT;
                    phase_cfg.undervolt_limit_mv = RST_UNDERVOLT;
                    phase_cfg.cc_start_below_mv  = RST_CC_START;
                    phase_cfg.cv_switch_at_mv    = RST_CV_SWITCH;
                    phase_cfg.recharge_below_mv  = RST_RECHARGE;
                    phase_cfg.taper_current_ma   = RST_TAPER;
                    phase_cfg.slow_tick_ms       = 16'hFFFF;
                end
                1:
                begin
                    phase_cfg = '0;
                    phase_cfg.slow_tick_ms = 16'd1;
                end
                2:
                begin
                    phase_cfg = '1;
                end
                3:
                begin
                    // zero step: timers frozen, clear rules still apply
                    phase_cfg.slow_tick_ms = 16'd0;
                end
                4, 5:
                begin
                    phase_cfg.undervolt_limit_mv = MV_W'($urandom_range(0, 8000));
                    phase_cfg.overvolt_limit_mv  = MV_W'($urandom_range(12000, 16'hFFFF));
                    phase_cfg.cc_start_below_mv  = any_value();
                    phase_cfg.cv_switch_at_mv    = any_value();
                    phase_cfg.recharge_below_mv  = any_value();
                    phase_cfg.taper_current_ma   = MV_W'($urandom_range(0, 5000));
                    phase_cfg.slow_tick_ms       = MV_W'($urandom_range(20000, 16'hFFFF));
                end
                default:
                begin
                    phase_cfg.overvolt_limit_mv  = RST_OVERVOLT;
                    phase_cfg.undervolt_limit_mv = RST_UNDERVOLT;
                    phase_cfg.cc_start_below_mv  = RST_CC_START;
                    phase_cfg.cv_switch_at_mv    = RST_CV_SWITCH;
                    phase_cfg.recharge_below_mv  = RST_RECHARGE;
                    phase_cfg.taper_current_ma   = RST_TAPER;
                    phase_cfg.slow_tick_ms       = RST_SLOW_TICK;
                end
            endcase
            program_config(phase_cfg);
            steady_flow = (phase == 2);
            random_traffic(RANDOM_ITEMS / PHASES);
            wait_for_results();
        end
        steady_flow = 1'b0;

        if (fail_count == 0 && pending_results == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

// File: files.f
src/css_pkg.sv
src/css_cfg_regs.sv
src/css_step.sv
src/css_core.sv
src/charge_stage_sequencer_top.sv
bench/charge_stage_checker.sv
bench/tb_top.sv
